@@ design/tte_pkg.sv @@
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants for the tap tempo feedback echo
// Sizes of the delay memory, the tap window and the sample path, register
// indexes and the records that pass between the front and back parts.
// ----------------------------------------------------------------------------
package tte_pkg;

  // Delay memory and sample path
  localparam int unsigned DELAY_DEPTH = 131072;
  localparam int unsigned ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned Q15_FRAC    = 15;
  localparam int unsigned PROD_W      = SAMPLE_BITS + GAIN_W + 1;

  // Tap tempo
  localparam int unsigned TAP_WINDOW     = 4;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned DEB_W          = 11;
  localparam int unsigned MAX_TAP_MS     = 2000;
  localparam int unsigned SAMPLES_PER_MS = 96000 / 2000;
  localparam int unsigned RESET_DELAY    = 24000;
  localparam int unsigned RESET_DELAY_CLAMP =
      (RESET_DELAY > DELAY_DEPTH - 1) ? DELAY_DEPTH - 1 : RESET_DELAY;
  localparam int unsigned INT_W  = $clog2(MAX_TAP_MS);
  localparam int unsigned SLOT_W = (TAP_WINDOW > 1) ? $clog2(TAP_WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(TAP_WINDOW + 1);
  localparam int unsigned SUM_W  = $clog2(TAP_WINDOW * (MAX_TAP_MS - 1) + 1);
  localparam int unsigned STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam int unsigned DLY_PROD_W = SUM_W + $clog2(SAMPLES_PER_MS + 1);
  localparam int unsigned DLY_CMP_W  = ((DLY_PROD_W > ADDR_W) ? DLY_PROD_W : ADDR_W) + 1;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 2'd2;
  localparam logic [GAIN_W-1:0]    GAIN_RESET        = 16'd32768;
  localparam logic [DEB_W-1:0]     DEBOUNCE_RESET    = 11'd200;

  // Item kinds
  localparam logic MODE_AUDIO = 1'b0;
  localparam logic MODE_TAP   = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] feedback_gain;
    logic [GAIN_W-1:0] wet_level;
    logic [DEB_W-1:0]  debounce_ms;
  } tte_cfg_t;

  // One audio transaction on its way to the back part
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [ADDR_W-1:0]             delay;
  } tte_item_t;

endpackage

@@ design/tap_tempo_feedback_echo.sv @@
// ----------------------------------------------------------------------------
// tap_tempo_feedback_echo: mono feedback echo with tap tempo
// Each audio transaction is queued, then read from the delay memory, scaled
// and written back; the back part takes no new transaction until that read,
// multiply, write loop on the single port of the delay memory is through.
// A tap press that updates the tempo stalls the input while the bit-serial
// average and scaling run; other button polls do not stall it. After reset
// the delay memory is cleared with the input stalled; registers take defaults.
// ----------------------------------------------------------------------------
module tap_tempo_feedback_echo (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tte_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [tte_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   mode_i,
  input  logic signed [tte_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                   button_level_i,
  input  logic [tte_pkg::TIME_W-1:0]             time_ms_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [tte_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import tte_pkg::*;

  tte_cfg_t  cfg_q, cfg_d;
  logic      clearing;
  logic      fifo_full, fifo_empty;
  logic      push, pop;
  tte_item_t push_data, pop_data;

  // register writes; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FEEDBACK_GAIN: cfg_d.feedback_gain = cfg_data_i[GAIN_W-1:0];
        CFG_WET_LEVEL:     cfg_d.wet_level     = cfg_data_i[GAIN_W-1:0];
        CFG_DEBOUNCE_MS:   cfg_d.debounce_ms   = cfg_data_i[DEB_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feedback_gain <= GAIN_RESET;
      cfg_q.wet_level     <= GAIN_RESET;
      cfg_q.debounce_ms   <= DEBOUNCE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tte_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .clearing_i     (clearing),
    .fifo_full_i    (fifo_full),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .sample_in_i    (sample_in_i),
    .button_level_i (button_level_i),
    .time_ms_i      (time_ms_i),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  tte_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (pop_data)
  );

  tte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clearing_o   (clearing),
    .fifo_empty_i (fifo_empty),
    .item_i       (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

endmodule

@@ design/tte_ram.sv @@
// ----------------------------------------------------------------------------
// tte_ram: generic single-port RAM
// One read or write per cycle at one address, read data registered.
// ----------------------------------------------------------------------------
module tte_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tte_fifo.sv @@
// ----------------------------------------------------------------------------
// tte_fifo: short queue between the front and back parts
// Holds audio transactions together with the delay length in force when
// they were accepted.
// ----------------------------------------------------------------------------
module tte_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tte_pkg::tte_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output tte_pkg::tte_item_t pop_data_o
);
  import tte_pkg::*;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  tte_item_t         entry_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o     = (count_q == CntW'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

@@ design/tte_front.sv @@
// ----------------------------------------------------------------------------
// tte_front: input acceptance and tap tempo tracking
// Queues audio transactions with the current delay length; handles button
// polls: debounce, rolling interval window, average by a bit-serial divider
// and scaling to a delay length in samples.
// ----------------------------------------------------------------------------
module tte_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  tte_pkg::tte_cfg_t                         cfg_i,
  input  logic                                      clearing_i,
  input  logic                                      fifo_full_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      mode_i,
  input  logic signed [tte_pkg::SAMPLE_BITS-1:0]    sample_in_i,
  input  logic                                      button_level_i,
  input  logic [tte_pkg::TIME_W-1:0]                time_ms_i,
  output logic                                      push_o,
  output tte_pkg::tte_item_t                        push_data_o
);
  import tte_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [TIME_W-1:0] last_tap_q, last_tap_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [ADDR_W-1:0] delay_q, delay_d;
  logic [INT_W-1:0]  window_q [TAP_WINDOW];

  // divider
  logic [SUM_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W:0]    rem_shift, rem_trial;
  logic              quo_bit;

  logic              accept;
  logic              press;
  logic [TIME_W-1:0] interval;
  logic              debounced;
  logic              short_tap;
  logic              win_full;
  logic              win_write;
  logic [SUM_W-1:0]  sum_drop;
  logic [DLY_PROD_W-1:0] dly_prod;

  assign in_stall_o = clearing_i || fifo_full_i || (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign press      = accept && (mode_i == MODE_TAP) && button_level_i;
  assign interval   = time_ms_i - last_tap_q;
  assign debounced  = interval > TIME_W'(cfg_i.debounce_ms);
  assign short_tap  = interval < TIME_W'(MAX_TAP_MS);
  assign win_full   = (count_q == CNT_W'(TAP_WINDOW));
  assign win_write  = press && debounced && short_tap;
  assign sum_drop   = win_full ? SUM_W'(window_q[slot_q]) : '0;

  assign push_o              = accept && (mode_i == MODE_AUDIO);
  assign push_data_o.sample  = sample_in_i;
  assign push_data_o.delay   = delay_q;

  // one restoring step per cycle; quotient bits shift in behind the dividend
  assign rem_shift = {rem_q, num_q[SUM_W-1]};
  assign rem_trial = rem_shift - {1'b0, den_q};
  assign quo_bit   = (rem_shift >= {1'b0, den_q});

  assign dly_prod  = DLY_PROD_W'(num_q) * DLY_PROD_W'(SAMPLES_PER_MS);

  always_comb begin
    state_d    = state_q;
    last_tap_d = last_tap_q;
    count_d    = count_q;
    slot_d     = slot_q;
    sum_d      = sum_q;
    delay_d    = delay_q;
    num_d      = num_q;
    den_d      = den_q;
    rem_d      = rem_q;
    step_d     = step_q;
    case (state_q)
      ST_IDLE: begin
        if (press && debounced) begin
          last_tap_d = time_ms_i;
          if (short_tap) begin
            count_d = win_full ? count_q : count_q + 1'b1;
            slot_d  = (slot_q == SLOT_W'(TAP_WINDOW - 1)) ? '0 : slot_q + 1'b1;
            sum_d   = sum_q - sum_drop + SUM_W'(interval[INT_W-1:0]);
            num_d   = sum_d;
            den_d   = count_d;
            rem_d   = '0;
            step_d  = '0;
            state_d = ST_DIV;
          end else begin
            // long gap: start a new tempo
            count_d = '0;
            slot_d  = '0;
            sum_d   = '0;
          end
        end
      end
      ST_DIV: begin
        rem_d  = quo_bit ? rem_trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        num_d  = {num_q[SUM_W-2:0], quo_bit};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (DLY_CMP_W'(dly_prod) > DLY_CMP_W'(DELAY_DEPTH - 1)) begin
          delay_d = ADDR_W'(DELAY_DEPTH - 1);
        end else begin
          delay_d = ADDR_W'(dly_prod);
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      last_tap_q <= '0;
      count_q    <= '0;
      slot_q     <= '0;
      sum_q      <= '0;
      delay_q    <= ADDR_W'(RESET_DELAY_CLAMP);
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      last_tap_q <= last_tap_d;
      count_q    <= count_d;
      slot_q     <= slot_d;
      sum_q      <= sum_d;
      delay_q    <= delay_d;
      step_q     <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    if (win_write) begin
      window_q[slot_q] <= interval[INT_W-1:0];
    end
  end

  a_tap_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_write |=> (state_q == ST_DIV) && (den_q != '0))
    else $error("accepted tap did not start the average");

  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !push_o)
    else $error("audio transaction queued while delay length is updating");

endmodule

@@ design/tte_back.sv @@
// ----------------------------------------------------------------------------
// tte_back: delay line engine
// Clears the delay memory after reset, then for each queued audio
// transaction reads the wet sample, scales it, writes the feedback sum back
// and presents the mix in the output register.
// ----------------------------------------------------------------------------
module tte_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tte_pkg::tte_cfg_t                      cfg_i,
  output logic                                   clearing_o,
  input  logic                                   fifo_empty_i,
  input  tte_pkg::tte_item_t                     item_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [tte_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import tte_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MUL   = 2'd2;
  localparam logic [1:0] ST_WR    = 2'd3;

  localparam logic signed [PROD_W-1:0] SAT_HI =  (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - 1'b1;
  localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) <<< (SAMPLE_BITS - 1));

  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [PROD_W-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  logic [1:0]                    state_q, state_d;
  logic [ADDR_W-1:0]             clr_addr_q, clr_addr_d;
  logic [ADDR_W-1:0]             wp_q, wp_d;
  logic signed [SAMPLE_BITS-1:0] dry_q;
  logic signed [PROD_W-1:0]      fb_prod_q, mix_prod_q;
  logic                          out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]        out_data_q;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_addr;
  logic [SAMPLE_BITS-1:0]        ram_wdata;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic [ADDR_W-1:0]             rd_addr;
  logic signed [PROD_W-1:0]      wet_ext;
  logic signed [PROD_W-1:0]      fb_sum, mix_sum;
  logic                          out_free;
  logic                          load_out;

  tte_ram #(
    .Width (SAMPLE_BITS),
    .Depth (DELAY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = (state_q == ST_CLEAR);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == ST_WR) && out_free;
  assign pop_o      = (state_q == ST_IDLE) && !fifo_empty_i;

  // read position behind the write pointer, wrapping around the ring
  assign rd_addr = (wp_q >= item_i.delay) ? wp_q - item_i.delay
                                          : ADDR_W'(DELAY_DEPTH) + wp_q - item_i.delay;

  assign wet_ext = PROD_W'($signed(ram_rdata));
  assign fb_sum  = (fb_prod_q >>> Q15_FRAC) + PROD_W'(dry_q);
  assign mix_sum = (mix_prod_q >>> Q15_FRAC) + PROD_W'(dry_q);

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    wp_d        = wp_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_addr    = wp_q;
    ram_wdata   = sat_sample(fb_sum);
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_q;
        ram_wdata = '0;
        if (clr_addr_q == ADDR_W'(DELAY_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_addr = rd_addr;
        if (pop_o) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          wp_d        = (wp_q == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dry_q <= item_i.sample;
    end
    if (state_q == ST_MUL) begin
      fb_prod_q  <= wet_ext * $signed(PROD_W'(cfg_i.feedback_gain));
      mix_prod_q <= wet_ext * $signed(PROD_W'(cfg_i.wet_level));
    end
    if (load_out) begin
      out_data_q <= sat_sample(mix_sum);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  a_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_WR)
    else $error("result appeared without a delay line write");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !pop_o)
    else $error("queue popped during the clearing pass");

endmodule
